### rtl/crcbs_pkg.sv
// ----------------------------------------------------------------------------
// crcbs_pkg
// Shared widths, register indexes, reset values and the state memory port
// type for the CRC-32 byte stream unit.
// ----------------------------------------------------------------------------
`default_nettype none

package crcbs_pkg;

  localparam int CRC_W    = 32;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CRC_W-1:0] POLY_RESET  = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] START_RESET = 32'h0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLYNOMIAL  = 2'd0,
    REG_START_VALUE = 2'd1
  } cfg_reg_t;

  // Request to the running-CRC store: one read and one write port.
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [CRC_W-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

### rtl/crcbs_state_mem.sv
// ----------------------------------------------------------------------------
// crcbs_state_mem
// Single-entry synchronous store for the running CRC, registered read with
// write-first forwarding and a valid flag cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module crcbs_state_mem (
  input  logic                     clk,
  input  logic                     rst,
  input  crcbs_pkg::mem_req_t      req,
  output logic [crcbs_pkg::CRC_W-1:0] rdata,
  output logic                     rvalid
);
  import crcbs_pkg::*;

  logic [CRC_W-1:0] mem_q;
  logic             valid;
  logic [CRC_W-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_q <= req.wdata;
    end
    // A write at the same edge as the read is forwarded to the read data.
    if (req.rd_en) begin
      rdata_q <= req.wr_en ? req.wdata : mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid <= 1'b1;
      end
      if (req.rd_en) begin
        rvalid_q <= req.wr_en | valid;
      end
    end
  end

  assign rdata  = rdata_q;
  assign rvalid = rvalid_q;

endmodule

`default_nettype wire

### rtl/crcbs_fold.sv
// ----------------------------------------------------------------------------
// crcbs_fold
// Folds one byte into a reflected CRC register: eight shift and
// conditional polynomial XOR steps, least significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module crcbs_fold (
  input  logic [crcbs_pkg::CRC_W-1:0]  crc_in,
  input  logic [crcbs_pkg::BYTE_W-1:0] byte_in,
  input  logic [crcbs_pkg::CRC_W-1:0]  polynomial,
  output logic [crcbs_pkg::CRC_W-1:0]  crc_out
);
  import crcbs_pkg::*;

  always_comb begin
    logic [CRC_W-1:0] r;
    logic             bit_out;
    r = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, byte_in};
    for (int k = 0; k < BYTE_W; k++) begin
      bit_out = r[0];
      r = {1'b0, r[CRC_W-1:1]};
      if (bit_out) begin
        r = r ^ polynomial;
      end
    end
    crc_out = r;
  end

endmodule

`default_nettype wire

### rtl/crc32_byte_stream_unit.sv
// ----------------------------------------------------------------------------
// crc32_byte_stream_unit
// Reflected CRC-32 over a byte stream with configurable polynomial and
// chaining start value.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the input channel (in_valid / in_stall) with data_byte
//   and last_byte. Every item gives exactly one result on the output channel
//   (out_valid / out_stall): crc_value is the inverted running CRC including
//   that byte, and message_end copies last_byte, so the result of the last
//   byte is the finished CRC. After a last byte the running CRC reloads from
//   the inverse of start_value.
//   The running CRC sits in a one-entry synchronous store. An item is read
//   from it at acceptance, then folded and written back when it leaves the
//   fold stage, as its result loads into the result register. A write
//   landing on the same edge as the next read is forwarded, so one item is
//   taken every cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds and one more item
//   waits in the fold stage; in_stall rises only while both are full.
//   Reset empties the pipeline and restores polynomial 0xEDB88320 and start
//   value zero; the store reads as the inverse of start_value until written.
//   Writing start_value reloads the running CRC at once; writing polynomial
//   applies from the next byte. Write configuration only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_byte_stream_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [crcbs_pkg::BYTE_W-1:0]      data_byte,
  input  logic                              last_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [crcbs_pkg::CRC_W-1:0]       crc_value,
  output logic                              message_end,
  input  logic                              cfg_write_en,
  input  logic [crcbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crcbs_pkg::CRC_W-1:0]       cfg_data
);
  import crcbs_pkg::*;

  logic [CRC_W-1:0]  polynomial;
  logic [CRC_W-1:0]  start_value;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;

  mem_req_t          mem_req;
  logic [CRC_W-1:0]  mem_rdata;
  logic              mem_rvalid;
  logic [CRC_W-1:0]  crc_cur;
  logic [CRC_W-1:0]  crc_next;

  logic              in_accept;
  logic              out_free;
  logic              s1_adv;
  logic              cfg_start_wr;

  assign out_free     = ~out_valid | ~out_stall;
  assign s1_adv       = s1_valid & out_free;
  assign in_stall     = s1_valid & ~out_free;
  assign in_accept    = in_valid & ~in_stall;
  assign cfg_start_wr = cfg_write_en & (cfg_index == REG_START_VALUE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial  <= POLY_RESET;
      start_value <= START_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_POLYNOMIAL:  polynomial  <= cfg_data;
        REG_START_VALUE: start_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Store port: a start value write takes priority over the write-back.
  always_comb begin
    mem_req.rd_en = in_accept;
    mem_req.wr_en = cfg_start_wr | s1_adv;
    if (cfg_start_wr) begin
      mem_req.wdata = ~cfg_data;
    end else if (s1_last) begin
      mem_req.wdata = ~start_value;
    end else begin
      mem_req.wdata = crc_next;
    end
  end

  crcbs_state_mem u_mem (
    .clk    (clk),
    .rst    (rst),
    .req    (mem_req),
    .rdata  (mem_rdata),
    .rvalid (mem_rvalid)
  );

  assign crc_cur = mem_rvalid ? mem_rdata : ~start_value;

  crcbs_fold u_fold (
    .crc_in     (crc_cur),
    .byte_in    (s1_byte),
    .polynomial (polynomial),
    .crc_out    (crc_next)
  );

  // Fold stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      crc_value   <= ~crc_next;
      message_end <= s1_last;
    end
  end

endmodule

`default_nettype wire

### rtl/crcbs_checker.sv
// ----------------------------------------------------------------------------
// crcbs_checker
// Port-level checks for the CRC-32 byte stream unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crcbs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [crcbs_pkg::CRC_W-1:0]  crc_value,
  input logic                         message_end
);
  import crcbs_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(crc_value) && $stable(message_end))
    else $error("stalled result changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // The input is held back only while a result waits on a stalled receiver.
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // After an accepted item, the output is checked to hold a valid result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("no result two cycles after an accepted item");

endmodule

bind crc32_byte_stream_unit crcbs_checker u_crcbs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .crc_value   (crc_value),
  .message_end (message_end)
);

`default_nettype wire
